@@ hdl/composite_line_decode_rgb_unit_defines.svh @@
// assertion macros for the composite line decoder checker
// no dependencies; included by the checker file only
`ifndef COMPOSITE_LINE_DECODE_RGB_UNIT_DEFINES_SVH
`define COMPOSITE_LINE_DECODE_RGB_UNIT_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define CLDR_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define CLDR_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/cldr_pkg.sv @@
// shared types, constants and coefficient tables for the composite line decoder
// no dependencies
package cldr_pkg;

  // default line length in samples
  localparam int LINE_LEN_DEF = 1024;

  // field widths
  localparam int PIX_W     = 12;
  localparam int SIDX_W    = 10;
  localparam int SMP_W     = 16;
  localparam int IW_W      = 13;
  localparam int GAIN_W    = 16;
  localparam int WGT_W     = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CH_W      = 8;

  // datapath widths
  localparam int YS_W   = 18;
  localparam int IQ_W   = 34;
  localparam int Y_W    = 35;
  localparam int MA_W   = 37;
  localparam int MB_W   = 17;
  localparam int PROD_W = MA_W + MB_W;
  localparam int ACC_W  = 56;
  localparam int FIN_W  = 64;

  // fixed-point shifts
  localparam int FRAC_SHIFT = 14;
  localparam int ROUND_HALF = 8192;
  localparam int OUT_SHIFT  = 41;

  // register reset values
  localparam logic [IW_W-1:0]          IMAGE_WIDTH_RST = 13'd640;
  localparam logic [GAIN_W-1:0]        LUMA_GAIN_RST   = 16'd8192;
  localparam logic [GAIN_W-1:0]        INPHASE_RST     = 16'd24166;
  localparam logic [GAIN_W-1:0]        QUADRATURE_RST  = 16'd16220;
  localparam logic signed [WGT_W-1:0]  WGT0_RST        = 16'sd15170;
  localparam logic signed [WGT_W-1:0]  WGT1_RST        = 16'sd6349;
  localparam logic signed [WGT_W-1:0]  WGT2_RST        = -16'sd6193;
  localparam logic signed [WGT_W-1:0]  WGT3_RST        = -16'sd15075;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH = 3'd0,
    REG_LUMA_GAIN   = 3'd1,
    REG_INPHASE     = 3'd2,
    REG_QUADRATURE  = 3'd3,
    REG_WEIGHT0     = 3'd4,
    REG_WEIGHT1     = 3'd5,
    REG_WEIGHT2     = 3'd6,
    REG_WEIGHT3     = 3'd7
  } cfg_reg_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_ALIGN,
    ST_LOAD,
    ST_MAC,
    ST_MAT,
    ST_DONE
  } state_t;

  // colour channel codes
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  // matrix column for I, Q.14
  function automatic logic signed [WGT_W-1:0] coef_i(input logic [1:0] ch);
    logic signed [WGT_W-1:0] c;
    case (ch)
      CH_RED:   c = 16'sd15514;
      CH_GREEN: c = -16'sd4502;
      CH_BLUE:  c = -16'sd18162;
      default:  c = '0;
    endcase
    return c;
  endfunction

  // matrix column for Q, Q.14
  function automatic logic signed [WGT_W-1:0] coef_q(input logic [1:0] ch);
    logic signed [WGT_W-1:0] c;
    case (ch)
      CH_RED:   c = 16'sd10216;
      CH_GREEN: c = -16'sd10415;
      CH_BLUE:  c = 16'sd28000;
      default:  c = '0;
    endcase
    return c;
  endfunction

endpackage

@@ hdl/cldr_ram.sv @@
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module cldr_ram #(
  parameter int DW    = 16,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/composite_line_decode_rgb_unit.sv @@
// Composite line decoder. A write transfer (op 0) stores one sample in the line
// memory without stalling the input. A decode transfer (op 1) runs through a
// sequencer: a bit-serial divider maps the pixel to a line offset, an align
// state aligns the offset, eight line memory reads fetch the samples, and a
// single shared multiplier does the chroma demodulation and gains and then the
// colour matrix with clamping. The input is stalled from accept to result; the
// next transfer is taken in the cycle after the result is registered, while
// the result still waits on out_stall.
// Depends on cldr_pkg and cldr_ram.
module composite_line_decode_rgb_unit #(
  parameter int LINE_LEN = cldr_pkg::LINE_LEN_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_op,
  input  logic [cldr_pkg::SIDX_W-1:0]         in_sample_index,
  input  logic signed [cldr_pkg::SMP_W-1:0]   in_sample_value,
  input  logic [cldr_pkg::PIX_W-1:0]          in_pixel_index,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [cldr_pkg::PIX_W-1:0]          out_pixel_number,
  output logic [cldr_pkg::CH_W-1:0]           out_red,
  output logic [cldr_pkg::CH_W-1:0]           out_green,
  output logic [cldr_pkg::CH_W-1:0]           out_blue,
  input  logic                                cfg_wr_en,
  input  logic [cldr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cldr_pkg::CFG_W-1:0]          cfg_wdata
);

  localparam int AW      = $clog2(LINE_LEN);
  localparam int NUM_W   = AW + cldr_pkg::PIX_W;
  localparam int CNT_W   = $clog2(NUM_W + 1);
  localparam int OFF_MAX = LINE_LEN - 4;
  localparam int IW_W    = cldr_pkg::IW_W;
  localparam int MA_W    = cldr_pkg::MA_W;
  localparam int MB_W    = cldr_pkg::MB_W;
  localparam int PROD_W  = cldr_pkg::PROD_W;
  localparam int ACC_W   = cldr_pkg::ACC_W;
  localparam int FIN_W   = cldr_pkg::FIN_W;

  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(NUM_W - 1);
  localparam logic [CNT_W-1:0] LOAD_LAST = CNT_W'(8);
  localparam logic [CNT_W-1:0] MAC_Y     = CNT_W'(8);
  localparam logic [CNT_W-1:0] MAC_I     = CNT_W'(9);
  localparam logic [CNT_W-1:0] MAC_Q     = CNT_W'(10);

  // matrix phases per channel
  localparam logic [1:0] PH_CI  = 2'd0;
  localparam logic [1:0] PH_CQ  = 2'd1;
  localparam logic [1:0] PH_FIN = 2'd2;

  // configuration registers
  logic [IW_W-1:0]                         iw_r;
  logic [cldr_pkg::GAIN_W-1:0]             lg_r, ig_r, qg_r;
  logic signed [cldr_pkg::WGT_W-1:0]       w_r [4];

  // sequencer
  cldr_pkg::state_t                        state_r, state_nxt;
  logic [CNT_W-1:0]                        cnt_r, cnt_nxt;
  logic [1:0]                              ch_r, ch_nxt;
  logic [1:0]                              ph_r, ph_nxt;
  logic                                    out_load;
  logic                                    in_fire;

  // datapath
  logic [NUM_W-1:0]                        quo_r;
  logic [IW_W-1:0]                         rem_r, den_r;
  logic [IW_W:0]                           div_sh;
  logic [IW_W+1:0]                         div_sub;
  logic                                    div_borrow;
  logic [cldr_pkg::PIX_W-1:0]              pix_r;
  logic [AW-1:0]                           off_r, al_r, off_w, al_w;
  logic [AW:0]                             al_t;
  logic [AW-1:0]                           raddr;
  logic signed [cldr_pkg::SMP_W-1:0]       rd_data;
  logic [2:0]                              ld_idx;
  logic signed [cldr_pkg::SMP_W-1:0]       smp_r [4];
  logic signed [cldr_pkg::YS_W-1:0]        ys_r;
  logic signed [cldr_pkg::IQ_W-1:0]        is_r, qs_r;
  logic signed [cldr_pkg::Y_W-1:0]         y_r;
  logic signed [MA_W-1:0]                  i_r, q_r;
  logic signed [ACC_W-1:0]                 acc_r;
  logic signed [FIN_W-1:0]                 fin;
  logic [cldr_pkg::CH_W-1:0]               fin_val;
  logic [cldr_pkg::CH_W-1:0]               rgb_r [3];
  logic [1:0]                              wi;
  logic signed [MA_W-1:0]                  mul_a;
  logic signed [MB_W-1:0]                  mul_b;
  logic signed [PROD_W-1:0]                prod, prod_rnd;
  logic                                    wr_in_range;

  // output registers
  logic                                    out_valid_r;
  logic [cldr_pkg::PIX_W-1:0]              out_pix_r;
  logic [cldr_pkg::CH_W-1:0]               out_red_r, out_green_r, out_blue_r;

  assign in_stall = (state_r != cldr_pkg::ST_IDLE);
  assign in_fire  = in_valid && !in_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iw_r   <= cldr_pkg::IMAGE_WIDTH_RST;
      lg_r   <= cldr_pkg::LUMA_GAIN_RST;
      ig_r   <= cldr_pkg::INPHASE_RST;
      qg_r   <= cldr_pkg::QUADRATURE_RST;
      w_r[0] <= cldr_pkg::WGT0_RST;
      w_r[1] <= cldr_pkg::WGT1_RST;
      w_r[2] <= cldr_pkg::WGT2_RST;
      w_r[3] <= cldr_pkg::WGT3_RST;
    end else if (cfg_wr_en) begin
      case (cldr_pkg::cfg_reg_t'(cfg_index))
        cldr_pkg::REG_IMAGE_WIDTH: iw_r   <= cfg_wdata[IW_W-1:0];
        cldr_pkg::REG_LUMA_GAIN:   lg_r   <= cfg_wdata;
        cldr_pkg::REG_INPHASE:     ig_r   <= cfg_wdata;
        cldr_pkg::REG_QUADRATURE:  qg_r   <= cfg_wdata;
        cldr_pkg::REG_WEIGHT0:     w_r[0] <= cfg_wdata;
        cldr_pkg::REG_WEIGHT1:     w_r[1] <= cfg_wdata;
        cldr_pkg::REG_WEIGHT2:     w_r[2] <= cfg_wdata;
        cldr_pkg::REG_WEIGHT3:     w_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // line memory: writes on a sample transfer, reads during load
  assign wr_in_range = (32'(in_sample_index) < LINE_LEN);
  assign raddr = cnt_r[2] ? AW'(al_r + AW'(cnt_r[1:0])) : AW'(off_r + AW'(cnt_r[1:0]));

  cldr_ram #(
    .DW    (cldr_pkg::SMP_W),
    .DEPTH (LINE_LEN)
  ) u_line_ram (
    .clk   (clk),
    .we    (in_fire && !in_op && wr_in_range),
    .waddr (AW'(in_sample_index)),
    .wdata (in_sample_value),
    .raddr (raddr),
    .rdata (rd_data)
  );

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cldr_pkg::ST_IDLE;
      cnt_r   <= '0;
      ch_r    <= '0;
      ph_r    <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ch_r    <= ch_nxt;
      ph_r    <= ph_nxt;
    end
  end

  // next state and sequencer outputs
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ch_nxt    = ch_r;
    ph_nxt    = ph_r;
    out_load  = 1'b0;
    case (state_r)
      cldr_pkg::ST_IDLE: begin
        cnt_nxt = '0;
        if (in_fire && in_op) begin
          state_nxt = cldr_pkg::ST_DIV;
        end
      end
      cldr_pkg::ST_DIV: begin
        if (cnt_r == DIV_LAST) begin
          state_nxt = cldr_pkg::ST_ALIGN;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      cldr_pkg::ST_ALIGN: begin
        state_nxt = cldr_pkg::ST_LOAD;
        cnt_nxt   = '0;
      end
      cldr_pkg::ST_LOAD: begin
        if (cnt_r == LOAD_LAST) begin
          state_nxt = cldr_pkg::ST_MAC;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      cldr_pkg::ST_MAC: begin
        if (cnt_r == MAC_Q) begin
          state_nxt = cldr_pkg::ST_MAT;
          cnt_nxt   = '0;
          ch_nxt    = cldr_pkg::CH_RED;
          ph_nxt    = PH_CI;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      cldr_pkg::ST_MAT: begin
        if (ph_r == PH_FIN) begin
          ph_nxt = PH_CI;
          if (ch_r == cldr_pkg::CH_BLUE) begin
            state_nxt = cldr_pkg::ST_DONE;
          end else begin
            ch_nxt = ch_r + 1'b1;
          end
        end else begin
          ph_nxt = ph_r + 1'b1;
        end
      end
      cldr_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = cldr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cldr_pkg::ST_IDLE;
    endcase
  end

  // restoring divider step
  assign div_sh     = {rem_r, quo_r[NUM_W-1]};
  assign div_sub    = {1'b0, div_sh} - {2'b00, den_r};
  assign div_borrow = div_sub[IW_W+1];

  // offset saturation and alignment to a multiple of four
  always_comb begin
    off_w = (quo_r > NUM_W'(OFF_MAX)) ? AW'(OFF_MAX) : quo_r[AW-1:0];
    al_t  = {1'b0, off_w} + (AW+1)'(1);
    al_t  = {al_t[AW:2], 2'b00};
    if ((al_t + (AW+1)'(3)) >= (AW+1)'(LINE_LEN)) begin
      al_w = AW'(al_t - (AW+1)'(4));
    end else begin
      al_w = al_t[AW-1:0];
    end
  end

  // shared multiplier operand select
  assign wi = cnt_r[0] ? cnt_r[2:1] : cnt_r[2:1] + 2'd1;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      cldr_pkg::ST_MAC: begin
        if (cnt_r < MAC_Y) begin
          mul_a = MA_W'(smp_r[cnt_r[2:1]]);
          mul_b = MB_W'(w_r[wi]);
        end else if (cnt_r == MAC_Y) begin
          mul_a = MA_W'(ys_r);
          mul_b = {1'b0, lg_r};
        end else if (cnt_r == MAC_I) begin
          mul_a = MA_W'(is_r);
          mul_b = {1'b0, ig_r};
        end else begin
          mul_a = MA_W'(qs_r);
          mul_b = {1'b0, qg_r};
        end
      end
      cldr_pkg::ST_MAT: begin
        if (ph_r == PH_CI) begin
          mul_a = i_r;
          mul_b = MB_W'(cldr_pkg::coef_i(ch_r));
        end else begin
          mul_a = q_r;
          mul_b = MB_W'(cldr_pkg::coef_q(ch_r));
        end
      end
      default: ;
    endcase
  end

  assign prod     = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign prod_rnd = prod + $signed(PROD_W'(cldr_pkg::ROUND_HALF));

  // scale by 255, clamp and truncate
  always_comb begin
    fin = (FIN_W'(acc_r) <<< 8) - FIN_W'(acc_r);
    if (fin <= 0) begin
      fin_val = '0;
    end else if (|fin[FIN_W-1:cldr_pkg::OUT_SHIFT+cldr_pkg::CH_W]) begin
      fin_val = '1;
    end else begin
      fin_val = fin[cldr_pkg::OUT_SHIFT+cldr_pkg::CH_W-1:cldr_pkg::OUT_SHIFT];
    end
  end

  assign ld_idx = 3'(cnt_r - 1'b1);

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      cldr_pkg::ST_IDLE: begin
        if (in_fire && in_op) begin
          quo_r <= NUM_W'(NUM_W'(OFF_MAX) * NUM_W'(in_pixel_index));
          rem_r <= '0;
          den_r <= (iw_r == '0) ? IW_W'(1) : iw_r;
          pix_r <= in_pixel_index;
        end
      end
      cldr_pkg::ST_DIV: begin
        rem_r <= div_borrow ? div_sh[IW_W-1:0] : div_sub[IW_W-1:0];
        quo_r <= {quo_r[NUM_W-2:0], ~div_borrow};
      end
      cldr_pkg::ST_ALIGN: begin
        off_r <= off_w;
        al_r  <= al_w;
        ys_r  <= '0;
        is_r  <= '0;
        qs_r  <= '0;
      end
      cldr_pkg::ST_LOAD: begin
        if (cnt_r != '0) begin
          if (!ld_idx[2]) begin
            ys_r <= ys_r + cldr_pkg::YS_W'(rd_data);
          end else begin
            smp_r[ld_idx[1:0]] <= rd_data;
          end
        end
      end
      cldr_pkg::ST_MAC: begin
        if (cnt_r < MAC_Y) begin
          if (cnt_r[0]) begin
            qs_r <= qs_r + cldr_pkg::IQ_W'(prod);
          end else begin
            is_r <= is_r + cldr_pkg::IQ_W'(prod);
          end
        end else if (cnt_r == MAC_Y) begin
          y_r <= cldr_pkg::Y_W'(prod);
        end else if (cnt_r == MAC_I) begin
          i_r <= MA_W'(prod_rnd >>> cldr_pkg::FRAC_SHIFT);
        end else begin
          q_r <= MA_W'(prod_rnd >>> cldr_pkg::FRAC_SHIFT);
        end
      end
      cldr_pkg::ST_MAT: begin
        case (ph_r)
          PH_CI:   acc_r <= (ACC_W'(y_r) <<< cldr_pkg::FRAC_SHIFT) + ACC_W'(prod);
          PH_CQ:   acc_r <= acc_r + ACC_W'(prod);
          default: rgb_r[ch_r] <= fin_val;
        endcase
      end
      default: ;
    endcase
  end

  // result register, holds while the far side stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pix_r   <= pix_r;
      out_red_r   <= rgb_r[cldr_pkg::CH_RED];
      out_green_r <= rgb_r[cldr_pkg::CH_GREEN];
      out_blue_r  <= rgb_r[cldr_pkg::CH_BLUE];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_number = out_pix_r;
  assign out_red          = out_red_r;
  assign out_green        = out_green_r;
  assign out_blue         = out_blue_r;

endmodule

@@ hdl/cldr_chk.sv @@
// port-level checker for the composite line decoder, bound to the top level
// depends on cldr_pkg and composite_line_decode_rgb_unit_defines.svh
`include "composite_line_decode_rgb_unit_defines.svh"

module cldr_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              in_op,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [cldr_pkg::PIX_W-1:0]        out_pixel_number,
  input logic [cldr_pkg::CH_W-1:0]         out_red,
  input logic [cldr_pkg::CH_W-1:0]         out_green,
  input logic [cldr_pkg::CH_W-1:0]         out_blue
);

  // a decode transfer keeps the input busy
  `CLDR_ASSERT_NEXT(a_decode_busy, clk, rst_n, in_valid && !in_stall && in_op, in_stall, "decode transfer did not stall input")

  // a sample write does not stall the input
  `CLDR_ASSERT_NEXT(a_write_single, clk, rst_n, in_valid && !in_stall && !in_op, !in_stall, "sample write stalled input")

  // a new result only appears at the end of a decode
  `CLDR_ASSERT_NOW(a_result_from_busy, clk, rst_n, $rose(out_valid), $past(in_stall), "result without a decode")

  // stalled result holds
  `CLDR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_pixel_number) && $stable(out_red) && $stable(out_green) && $stable(out_blue), "stalled result changed")

endmodule

bind composite_line_decode_rgb_unit cldr_chk u_cldr_chk (.*);
